// ===== hw/rtl/tccw_pkg.sv =====
// Package for the text console cell writer: field widths, codes, channel
// payload structs and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int KIND_W  = 3;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int SPAN_W  = 11;
  localparam int CELL_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SETCUR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HIDE  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_DEF_FORE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEF_BACK = 1'd1;

  localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0]  CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CHAR_LF    = 8'h0A;
  localparam logic [COLOR_W-1:0] RESET_FORE = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BACK = 4'd0;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic               at_cursor;
    logic [CHAR_W-1:0]  character;
    logic [COLOR_W-1:0] fore_code;
    logic [COLOR_W-1:0] back_code;
    logic               use_defaults;
    logic               critical_mode;
    logic [SPAN_W-1:0]  span_length;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              cursor_visible;
    logic              did_scroll;
  } out_item_t;

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic init_step;
    logic dispatch;
    logic clear_step;
    logic scroll_move;
    logic scroll_zero;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic scroll_req;
    logic clear_none;
    logic clear_last;
    logic init_last;
    logic move_last;
    logic zero_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tccw_if.sv =====
// Valid/ready channel interfaces for the item and result streams.
// Depends on tccw_pkg.
`default_nettype none

interface tccw_item_if;
  import tccw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tccw_result_if;
  import tccw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller FSM for the text console cell writer: sequences init sweep,
// item dispatch, clear, scroll and result load. Depends on tccw_pkg.
`default_nettype none

module tccw_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  tccw_pkg::dp_status_t  stat,
  output tccw_pkg::dp_cmd_t     cmd
);
  import tccw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_ZERO  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_next = S_DONE;
        if (stat.kind == KIND_CLEAR && !stat.clear_none) state_next = S_CLEAR;
        if (stat.kind == KIND_WRITE && stat.scroll_req) state_next = S_MOVE;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_DONE;
      end
      S_MOVE: begin
        cmd.scroll_move = 1'b1;
        if (stat.move_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.scroll_zero = 1'b1;
        if (stat.zero_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.in_ready = 1'b1;
          state_next = in_valid ? S_DISP : S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    cmd.latch = cmd.in_ready && in_valid;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tccw_datapath.sv =====
// Datapath for the text console cell writer: cell store memory, cursor,
// default colors, item latch, sweep pointer and result register.
// Depends on tccw_pkg.
`default_nettype none

module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  tccw_pkg::dp_cmd_t                      cmd,
  output tccw_pkg::dp_status_t                   stat,
  input  tccw_pkg::in_item_t                     in_item,
  input  wire                                    cfg_we,
  input  wire [tccw_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire [tccw_pkg::COLOR_W-1:0]            cfg_data,
  input  wire                                    out_ready,
  output logic                                   out_valid,
  output tccw_pkg::out_item_t                    out_item
);
  import tccw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = (AW + 1 > SPAN_W) ? AW + 1 : SPAN_W;

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);

  logic [CELL_W-1:0] mem [CELLS];

  // architectural state
  logic [CW-1:0]      cur_col;
  logic [RW-1:0]      cur_row;
  logic               cur_shown;
  logic [COLOR_W-1:0] def_fore;
  logic [COLOR_W-1:0] def_back;

  // latched item
  logic [KIND_W-1:0]  k_kind;
  logic [CW-1:0]      k_col;
  logic [RW-1:0]      k_row;
  logic [CELL_W-1:0]  k_cell;
  logic               k_crit;
  logic               k_crlf;
  logic [SPAN_W-1:0]  k_span;
  logic               k_scrolled;
  logic [AW-1:0]      addr;

  // sweep
  logic [AW-1:0]      ptr;
  logic [SW-1:0]      cnt;
  logic               mv_pend;
  logic [AW-1:0]      mv_addr;
  logic [CELL_W-1:0]  rdata;

  logic [CW-1:0]      col_clamp;
  logic [RW-1:0]      row_clamp;
  logic               use_cur;
  logic [CW-1:0]      eff_col;
  logic [RW-1:0]      eff_row;
  logic [COLOR_W-1:0] eff_fore;
  logic [COLOR_W-1:0] eff_back;
  logic [SW-1:0]      room;
  logic [SW-1:0]      span_ext;
  logic [SW-1:0]      clear_n;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               is_write;
  logic               ch_crlf;

  always_comb begin
    col_clamp = (int'(in_item.column) >= COLUMNS) ? COL_LAST : CW'(in_item.column);
    row_clamp = (int'(in_item.row) >= ROWS) ? ROW_LAST : RW'(in_item.row);
    use_cur   = (in_item.kind == KIND_WRITE) && in_item.at_cursor;
    eff_col   = use_cur ? cur_col : col_clamp;
    eff_row   = use_cur ? cur_row : row_clamp;
    eff_fore  = in_item.use_defaults ? def_fore : in_item.fore_code;
    eff_back  = in_item.use_defaults ? def_back : in_item.back_code;
    ch_crlf   = (in_item.character == CHAR_CR) || (in_item.character == CHAR_LF);
  end

  always_comb begin
    is_write = (k_kind == KIND_WRITE);
    room     = SW'(CELLS) - SW'(addr);
    span_ext = SW'(k_span);
    clear_n  = (span_ext > room) ? room : span_ext;

    stat.kind       = k_kind;
    stat.scroll_req = is_write && (k_crlf ? (cur_row == ROW_LAST)
                                          : (k_crit && k_col == COL_LAST && k_row == ROW_LAST));
    stat.clear_none = (k_span == '0);
    stat.clear_last = (cnt == SW'(1));
    stat.init_last  = (ptr == CELL_LAST);
    stat.move_last  = (ptr == CELL_LAST);
    stat.zero_last  = (ptr == CELL_LAST);
    stat.out_free   = !out_valid || out_ready;
  end

  // one write port, one read port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = BLANK_CELL;
    if (cmd.init_step || cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.dispatch && is_write && !k_crlf) begin
      wr_en   = 1'b1;
      wr_addr = addr;
      wr_data = k_cell;
    end else if (mv_pend) begin
      wr_en   = 1'b1;
      wr_addr = mv_addr;
      wr_data = rdata;
    end else if (cmd.scroll_zero) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end
    rd_en   = cmd.scroll_move || (cmd.dispatch && k_kind == KIND_READ);
    rd_addr = cmd.scroll_move ? ptr : addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      cur_shown <= 1'b0;
      def_fore  <= RESET_FORE;
      def_back  <= RESET_BACK;
      ptr       <= '0;
      cnt       <= '0;
      mv_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mv_pend <= cmd.scroll_move;

      if (cfg_we) begin
        case (cfg_index)
          REG_DEF_FORE: def_fore <= cfg_data;
          REG_DEF_BACK: def_back <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.init_step || cmd.clear_step || cmd.scroll_zero) ptr <= ptr + AW'(1);
      if (cmd.clear_step) cnt <= cnt - SW'(1);
      if (cmd.scroll_move) begin
        ptr <= (ptr == CELL_LAST) ? LAST_ROW_BASE : ptr + AW'(1);
      end

      if (cmd.dispatch) begin
        if (stat.scroll_req) ptr <= ROW_STRIDE;
        case (k_kind)
          KIND_WRITE: begin
            if (k_crlf) begin
              cur_shown <= 1'b0;
              cur_col   <= '0;
              if (cur_row != ROW_LAST) cur_row <= cur_row + RW'(1);
            end else if (k_col == COL_LAST) begin
              cur_col <= '0;
              if (k_row != ROW_LAST) cur_row <= k_row + RW'(1);
              else cur_row <= k_crit ? ROW_LAST : '0;
            end else begin
              cur_col <= k_col + CW'(1);
            end
          end
          KIND_CLEAR: begin
            ptr <= addr;
            cnt <= clear_n;
          end
          KIND_SETCUR: begin
            cur_col   <= k_col;
            cur_row   <= k_row;
            cur_shown <= 1'b1;
          end
          KIND_HIDE: cur_shown <= 1'b0;
          default: ;
        endcase
      end

      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      k_kind     <= in_item.kind;
      k_col      <= eff_col;
      k_row      <= eff_row;
      k_cell     <= {eff_back, eff_fore, in_item.character};
      k_crit     <= in_item.critical_mode;
      k_crlf     <= (in_item.kind == KIND_WRITE) && in_item.critical_mode && ch_crlf;
      k_span     <= in_item.span_length;
      k_scrolled <= 1'b0;
      addr       <= AW'(int'(eff_row) * COLUMNS + int'(eff_col));
    end else if (cmd.dispatch) begin
      k_scrolled <= stat.scroll_req;
    end
    if (cmd.scroll_move) mv_addr <= ptr - ROW_STRIDE;
    if (cmd.load_out) begin
      out_item.cell_data      <= (k_kind == KIND_READ) ? rdata : '0;
      out_item.cursor_column  <= COL_W'(cur_col);
      out_item.cursor_row     <= ROW_W'(cur_row);
      out_item.cursor_visible <= cur_shown;
      out_item.did_scroll     <= k_scrolled;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer: controller plus datapath.
// Depends on tccw_pkg, tccw_if, tccw_ctrl and tccw_datapath.
//
//   channel  dir  handshake         payload
//   item     in   valid/ready       tccw_pkg::in_item_t
//   result   out  valid/ready       tccw_pkg::out_item_t
//   cfg      in   cfg_we (no wait)  cfg_index, cfg_data
//
// Steps: write (no wrap scroll), set cursor, read and hide each pass the
//   dispatch state, then the result load state, which can accept the next item.
// Clear span: n cells, n = span clipped at the store end, one cell written per cycle.
// Scrolling write: adds a move sweep copying rows 1..ROWS-1 up a row, a drain
//   state and a zero sweep of the last row; the cell store's single write port sets this.
// Reset: a sweep over all COLUMNS*ROWS cells fills the store
//   with blanks; no item is taken then, config writes still are.
// Stalls: the result register holds a result while the next item is taken
//   and worked; that item waits in its final state until the register frees.
`default_nettype none

module text_console_cell_writer_unit #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  wire                               clk,
  input  wire                               rst,
  tccw_item_if.sink                         item,
  tccw_result_if.source                     result,
  input  wire                               cfg_we,
  input  wire [tccw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [tccw_pkg::COLOR_W-1:0]       cfg_data
);
  import tccw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  // sequencing
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, cursor and result register
  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (item.payload),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_item  (result.payload)
  );

  assign item.ready = cmd.in_ready;

`ifndef SYNTHESIS
  // no item taken during the reset fill sweep
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    cmd.init_step |-> !item.ready)
    else $error("item ready during init sweep");

  // at most one cell store access source per cycle
  a_one_sweep_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init_step, cmd.dispatch, cmd.clear_step, cmd.scroll_move,
              cmd.scroll_zero}))
    else $error("conflicting cell store commands");

  // an accepted item keeps the block busy for its dispatch cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> !item.ready && cmd.dispatch)
    else $error("no dispatch after accept");

  // a scrolled result leaves the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.did_scroll) |->
      (result.payload.cursor_row == ROW_W'(ROWS - 1)))
    else $error("scroll with cursor off last row");
`endif

endmodule

`default_nettype wire
